>>> rtl/bounded_id_set_top_defines.svh
// assertion macros shared by the checker of the bounded id set
`ifndef BOUNDED_ID_SET_TOP_DEFINES_SVH
`define BOUNDED_ID_SET_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bis_pkg.sv
// package: constants, codes and control types of the bounded id set
package bis_pkg;

  localparam int BIS_CAPACITY  = 128;
  localparam int BIS_KEY_WIDTH = 32;
  localparam int CNT_W         = 8;
  localparam int FIELD_W       = 32;
  localparam int POS_W         = 8;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_ADDR_W-3:0] REG_EMPTY_MARKER = '0;
  localparam logic [FIELD_W-1:0]    MARKER_RESET     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FN_ADD  = 2'd0,
    FN_DEL  = 2'd1,
    FN_FIND = 2'd2,
    FN_READ = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

  // control from the sequencer to every cell of the chain
  typedef struct packed {
    logic capture;  // register per-cell hit bits
    logic rd;       // hit means index match instead of key match
    logic do_add;   // append key at first free cell
    logic do_del;   // close the gap at the hit cell
  } ctrl_t;

endpackage

>>> rtl/bis_cell.sv
// one slot of the set: key, occupied flag and registered hit bit
module bis_cell #(
  parameter int KEY_WIDTH = bis_pkg::BIS_KEY_WIDTH,
  parameter int IDX       = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bis_pkg::ctrl_t            ctrl,
  input  logic [KEY_WIDTH-1:0]      key_q,
  input  logic [KEY_WIDTH-1:0]      marker,
  input  logic [bis_pkg::POS_W-1:0] pos,
  input  logic                      occ_prev,
  input  logic                      occ_next,
  input  logic [KEY_WIDTH-1:0]      key_next,
  input  logic                      shift_en,
  output logic [KEY_WIDTH-1:0]      key_o,
  output logic                      occ_o,
  output logic                      hit_o
);

  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 occ_r, occ_nxt;
  logic                 hit_r, hit_nxt;

  always_comb begin
    hit_nxt = hit_r;
    if (ctrl.capture) begin
      if (ctrl.rd) begin
        hit_nxt = occ_r && (pos == bis_pkg::POS_W'(IDX));
      end else begin
        hit_nxt = occ_r && (key_r == key_q);
      end
    end
  end

  always_comb begin
    key_nxt = key_r;
    occ_nxt = occ_r;
    if (ctrl.do_add && !occ_r && occ_prev) begin
      key_nxt = key_q;
      occ_nxt = 1'b1;
    end else if (ctrl.do_del && shift_en && occ_r) begin
      // take the neighbour's key, last occupied slot refills with the marker
      key_nxt = occ_next ? key_next : marker;
      occ_nxt = occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o = key_r;
  assign occ_o = occ_r;
  assign hit_o = hit_r;

endmodule

>>> rtl/bis_chain.sv
// row of slot cells with first-hit prefix and one-hot read selection
module bis_chain #(
  parameter int CAPACITY  = bis_pkg::BIS_CAPACITY,
  parameter int KEY_WIDTH = bis_pkg::BIS_KEY_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bis_pkg::ctrl_t            ctrl,
  input  logic [KEY_WIDTH-1:0]      key_q,
  input  logic [KEY_WIDTH-1:0]      marker,
  input  logic [bis_pkg::POS_W-1:0] pos,
  output logic                      found,
  output logic [KEY_WIDTH-1:0]      rd_val
);

  localparam int LV = $clog2(CAPACITY);

  logic [CAPACITY-1:0]  occ;
  logic [CAPACITY-1:0]  hit;
  logic [CAPACITY-1:0]  occ_prev_v;
  logic [CAPACITY-1:0]  occ_next_v;
  logic [KEY_WIDTH-1:0] keys      [CAPACITY];
  logic [KEY_WIDTH-1:0] keys_next [CAPACITY];
  logic [CAPACITY-1:0]  pre [LV+1];

  assign occ_prev_v = {occ[CAPACITY-2:0], 1'b1};
  assign occ_next_v = {1'b0, occ[CAPACITY-1:1]};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign keys_next[i] = marker;
    end else begin : g_mid
      assign keys_next[i] = keys[i+1];
    end

    bis_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .key_q    (key_q),
      .marker   (marker),
      .pos      (pos),
      .occ_prev (occ_prev_v[i]),
      .occ_next (occ_next_v[i]),
      .key_next (keys_next[i]),
      .shift_en (pre[LV][i]),
      .key_o    (keys[i]),
      .occ_o    (occ[i]),
      .hit_o    (hit[i])
    );
  end

  // log-depth prefix or: a cell shifts when the hit lies at or before it
  always_comb begin
    pre[0] = hit;
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
  end

  assign found = pre[LV][CAPACITY-1];

  // hit is one-hot on a read, so an and-or picks the slot
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_val = rd_val | (keys[i] & {KEY_WIDTH{hit[i]}});
    end
  end

endmodule

>>> rtl/bounded_id_set_top.sv
// bounded id set: one transaction per request, taken through input, compare and apply steps
// the result is registered when the apply step completes
// a new request is taken only in the input step, once the last one has left the apply step
// a stalled result holds the apply step, input is taken while the last result waits
// reset (synchronous, rst_n low): set empty, count zero, marker all ones, no result
module bounded_id_set_top #(
  parameter int CAPACITY  = bis_pkg::BIS_CAPACITY,
  parameter int KEY_WIDTH = bis_pkg::BIS_KEY_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_func,
  input  logic [bis_pkg::FIELD_W-1:0]    in_key,
  input  logic [bis_pkg::POS_W-1:0]      in_position,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_status,
  output logic [bis_pkg::FIELD_W-1:0]    out_read_value,
  output logic [bis_pkg::CNT_W-1:0]      out_occupancy,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bis_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bis_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int FW = bis_pkg::FIELD_W;
  localparam int CW = bis_pkg::CNT_W;

  bis_pkg::state_t state_r, state_nxt;
  bis_pkg::func_t  func_r;
  bis_pkg::ctrl_t  ctrl;

  logic [FW-1:0]            marker_r;
  logic [KEY_WIDTH-1:0]     key_r;
  logic [bis_pkg::POS_W-1:0] pos_r;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_status_r, out_status_nxt;
  logic [FW-1:0]            out_value_r, out_value_nxt;
  logic [CW-1:0]            out_occ_r;

  logic [KEY_WIDTH+FW-1:0]  key_ext, mk_ext;
  logic [FW+KEY_WIDTH-1:0]  rd_ext, mkout_ext;
  logic [KEY_WIDTH-1:0]     marker_k;
  logic [KEY_WIDTH-1:0]     rd_val;
  logic                     found, full, is_mk, accept, apply_go, cfg_wr, op_ok;

  assign key_ext   = {{KEY_WIDTH{1'b0}}, in_key};
  assign mk_ext    = {{KEY_WIDTH{1'b0}}, marker_r};
  assign marker_k  = mk_ext[KEY_WIDTH-1:0];
  assign rd_ext    = {{FW{1'b0}}, rd_val};
  assign mkout_ext = {{FW{1'b0}}, marker_k};

  assign accept   = in_valid && in_ready;
  assign apply_go = (state_r == bis_pkg::ST_APPLY) && (!out_valid_r || out_ready);
  assign is_mk    = (key_r == marker_k);
  assign full     = (count_r == CW'(CAPACITY));

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[bis_pkg::CFG_ADDR_W-1:2] == bis_pkg::REG_EMPTY_MARKER);
  assign cfg_prdata = (cfg_paddr[bis_pkg::CFG_ADDR_W-1:2] == bis_pkg::REG_EMPTY_MARKER) ?
                      marker_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= bis_pkg::MARKER_RESET;
    end else if (cfg_wr) begin
      marker_r <= cfg_pwdata;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bis_pkg::ST_IDLE:  if (accept) state_nxt = bis_pkg::ST_CMP;
      bis_pkg::ST_CMP:   state_nxt = bis_pkg::ST_APPLY;
      bis_pkg::ST_APPLY: if (apply_go) state_nxt = bis_pkg::ST_IDLE;
      default:           state_nxt = bis_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready     = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.rd      = (func_r == bis_pkg::FN_READ);
    ctrl.do_add  = 1'b0;
    ctrl.do_del  = 1'b0;
    case (state_r)
      bis_pkg::ST_IDLE: in_ready = 1'b1;
      bis_pkg::ST_CMP:  ctrl.capture = 1'b1;
      bis_pkg::ST_APPLY: begin
        ctrl.do_add = apply_go && (func_r == bis_pkg::FN_ADD) && !is_mk && !full && !found;
        ctrl.do_del = apply_go && (func_r == bis_pkg::FN_DEL) && !is_mk && found;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // result of the request
  always_comb begin
    case (func_r)
      bis_pkg::FN_ADD:  op_ok = !is_mk && !full && !found;
      bis_pkg::FN_DEL:  op_ok = !is_mk && found;
      bis_pkg::FN_FIND: op_ok = !is_mk && found;
      bis_pkg::FN_READ: op_ok = found;
      default:          op_ok = 1'b0;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    if (ctrl.do_add) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.do_del) begin
      count_nxt = count_r - CW'(1);
    end
    if (apply_go) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = !op_ok;
      out_value_nxt  = (func_r == bis_pkg::FN_READ && op_ok) ? rd_ext[FW-1:0]
                                                              : mkout_ext[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bis_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= bis_pkg::func_t'(in_func);
      key_r  <= key_ext[KEY_WIDTH-1:0];
      pos_r  <= in_position;
    end
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    if (apply_go) begin
      out_occ_r <= count_nxt;
    end
  end

  bis_chain #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .key_q  (key_r),
    .marker (marker_k),
    .pos    (pos_r),
    .found  (found),
    .rd_val (rd_val)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;
  assign out_occupancy  = out_occ_r;

endmodule

>>> rtl/bis_checker.sv
// port-level checker for the bounded id set, bound to the top level
`include "bounded_id_set_top_defines.svh"

module bis_checker #(
  parameter int CAPACITY = bis_pkg::BIS_CAPACITY
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_status,
  input logic [bis_pkg::FIELD_W-1:0]    out_read_value,
  input logic [bis_pkg::CNT_W-1:0]      out_occupancy,
  input logic                           cfg_psel,
  input logic                           cfg_penable,
  input logic                           cfg_pwrite,
  input logic [bis_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input logic [bis_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input logic [bis_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input logic                           cfg_pready
);

  // a stalled result keeps its fields
  `BIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_read_value) && $stable(out_occupancy), "result changed while stalled")

  // the set never reports more keys than it can hold
  `BIS_ASSERT_NOW(a_occ_bound, out_valid, out_occupancy <= bis_pkg::CNT_W'(CAPACITY), "occupancy beyond capacity")

  // one request at a time: input closes after a transaction
  `BIS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken during compare")

  // marker write is read back on the next cycle
  `BIS_ASSERT_NEXT(a_cfg_readback, cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == '0, cfg_prdata == $past(cfg_pwdata), "marker readback mismatch")

endmodule

bind bounded_id_set_top bis_checker #(.CAPACITY(CAPACITY)) u_bis_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_read_value (out_read_value),
  .out_occupancy  (out_occupancy),
  .cfg_psel       (cfg_psel),
  .cfg_penable    (cfg_penable),
  .cfg_pwrite     (cfg_pwrite),
  .cfg_paddr      (cfg_paddr),
  .cfg_pwdata     (cfg_pwdata),
  .cfg_prdata     (cfg_prdata),
  .cfg_pready     (cfg_pready)
);
